[design/hict_pkg.sv]
// Package for the hash/id cache table: codes, command and status types.
// Used by every module of the design; depends on nothing.
package hict_pkg;

   localparam int CAPACITY_DEF  = 256;
   localparam int HASH_BITS_DEF = 32;
   localparam int ID_BITS_DEF   = 16;
   localparam int HITS_BITS     = 16;
   localparam int COUNT_BITS    = 9;
   localparam int IN_BYTES_BITS = 64;
   localparam int OUT_BITS      = 24;

   localparam logic [2:0] FUNC_ADD    = 3'd0;
   localparam logic [2:0] FUNC_LOOKUP = 3'd1;
   localparam logic [2:0] FUNC_WIPE   = 3'd2;
   localparam logic [2:0] FUNC_SORT   = 3'd3;
   localparam logic [2:0] FUNC_EVICT  = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_RANGE    = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   localparam logic [8:0] LIMIT_RESET = 9'd256;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_ADD,
      CMD_RD,
      CMD_NEXT,
      CMD_LK_HIT,
      CMD_LK_MISS,
      CMD_WIPE,
      CMD_PASS_INIT,
      CMD_PASS_FIRST,
      CMD_PASS_STEP,
      CMD_PASS_END,
      CMD_CLR,
      CMD_SCAN_INIT,
      CMD_CMP_STEP,
      CMD_CMP_END,
      CMD_RESP
   } op_type;

   typedef struct packed {
      op_type op;
      logic   by_hits;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic match;
      logic last;
      logic swapped;
      logic by_hits;
      logic clr_done;
      logic few;
      logic evict_ok;
      logic rsp_free;
   } stat_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ADD,
      S_LK_RD,
      S_LK_CMP,
      S_WIPE,
      S_SORT,
      S_EVICT,
      S_PASS_RD0,
      S_PASS_FIRST,
      S_PASS_RD,
      S_PASS_STEP,
      S_PASS_END,
      S_PASS_AGAIN,
      S_CLR_INIT,
      S_CLR,
      S_CMP_INIT,
      S_CMP_RD,
      S_CMP_STEP,
      S_CMP_END,
      S_DONE
   } state_type;

endpackage

[design/hict_ctrl.sv]
// Sequencer of the hash/id cache table: steps each request through its scans.
// Depends on hict_pkg; drives the commands of hict_dpath.
module hict_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_take,
   input  logic [2:0]         req_func,
   input  hict_pkg::stat_type stat,
   output logic               idle,
   output hict_pkg::cmd_type  cmd
);

   hict_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hict_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hict_pkg::S_IDLE: begin
            if (req_take) begin
               case (req_func)
                  hict_pkg::FUNC_ADD:    state_in = hict_pkg::S_ADD;
                  hict_pkg::FUNC_LOOKUP: state_in = hict_pkg::S_LK_RD;
                  hict_pkg::FUNC_WIPE:   state_in = hict_pkg::S_WIPE;
                  hict_pkg::FUNC_SORT:   state_in = hict_pkg::S_SORT;
                  hict_pkg::FUNC_EVICT:  state_in = hict_pkg::S_EVICT;
                  default:               state_in = hict_pkg::S_DONE;
               endcase
            end
         end
         hict_pkg::S_ADD:  state_in = hict_pkg::S_DONE;
         hict_pkg::S_WIPE: state_in = hict_pkg::S_DONE;
         hict_pkg::S_LK_RD: begin
            state_in = stat.scan_done ? hict_pkg::S_DONE : hict_pkg::S_LK_CMP;
         end
         hict_pkg::S_LK_CMP: begin
            state_in = stat.match ? hict_pkg::S_DONE : hict_pkg::S_LK_RD;
         end
         hict_pkg::S_SORT: begin
            state_in = stat.few ? hict_pkg::S_DONE : hict_pkg::S_PASS_RD0;
         end
         hict_pkg::S_EVICT: begin
            state_in = stat.evict_ok ? hict_pkg::S_PASS_RD0 : hict_pkg::S_DONE;
         end
         hict_pkg::S_PASS_AGAIN: state_in = hict_pkg::S_PASS_RD0;
         hict_pkg::S_PASS_RD0:   state_in = hict_pkg::S_PASS_FIRST;
         hict_pkg::S_PASS_FIRST: state_in = hict_pkg::S_PASS_RD;
         hict_pkg::S_PASS_RD:    state_in = hict_pkg::S_PASS_STEP;
         hict_pkg::S_PASS_STEP: begin
            state_in = stat.last ? hict_pkg::S_PASS_END : hict_pkg::S_PASS_RD;
         end
         hict_pkg::S_PASS_END: begin
            if (stat.swapped) begin
               state_in = hict_pkg::S_PASS_AGAIN;
            end else if (stat.by_hits) begin
               state_in = hict_pkg::S_CLR_INIT;
            end else begin
               state_in = hict_pkg::S_CMP_INIT;
            end
         end
         hict_pkg::S_CLR_INIT: state_in = hict_pkg::S_CLR;
         hict_pkg::S_CLR: begin
            if (stat.clr_done) begin
               state_in = hict_pkg::S_SORT;
            end
         end
         hict_pkg::S_CMP_INIT: state_in = hict_pkg::S_CMP_RD;
         hict_pkg::S_CMP_RD: begin
            state_in = stat.scan_done ? hict_pkg::S_CMP_END : hict_pkg::S_CMP_STEP;
         end
         hict_pkg::S_CMP_STEP: state_in = hict_pkg::S_CMP_RD;
         hict_pkg::S_CMP_END:  state_in = hict_pkg::S_DONE;
         hict_pkg::S_DONE: begin
            if (stat.rsp_free) begin
               state_in = hict_pkg::S_IDLE;
            end
         end
         default: state_in = hict_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op      = hict_pkg::CMD_NONE;
      cmd.by_hits = 1'b0;
      idle        = 1'b0;
      case (state_ff)
         hict_pkg::S_IDLE: begin
            idle = 1'b1;
            if (req_take) begin
               cmd.op = hict_pkg::CMD_LOAD;
            end
         end
         hict_pkg::S_ADD:  cmd.op = hict_pkg::CMD_ADD;
         hict_pkg::S_WIPE: cmd.op = hict_pkg::CMD_WIPE;
         hict_pkg::S_LK_RD: begin
            cmd.op = stat.scan_done ? hict_pkg::CMD_LK_MISS : hict_pkg::CMD_RD;
         end
         hict_pkg::S_LK_CMP: begin
            cmd.op = stat.match ? hict_pkg::CMD_LK_HIT : hict_pkg::CMD_NEXT;
         end
         hict_pkg::S_SORT: begin
            if (!stat.few) begin
               cmd.op = hict_pkg::CMD_PASS_INIT;
            end
         end
         hict_pkg::S_EVICT: begin
            if (stat.evict_ok) begin
               cmd.op      = hict_pkg::CMD_PASS_INIT;
               cmd.by_hits = 1'b1;
            end
         end
         hict_pkg::S_PASS_AGAIN: begin
            cmd.op      = hict_pkg::CMD_PASS_INIT;
            cmd.by_hits = stat.by_hits;
         end
         hict_pkg::S_PASS_RD0:   cmd.op = hict_pkg::CMD_RD;
         hict_pkg::S_PASS_FIRST: cmd.op = hict_pkg::CMD_PASS_FIRST;
         hict_pkg::S_PASS_RD:    cmd.op = hict_pkg::CMD_RD;
         hict_pkg::S_PASS_STEP:  cmd.op = hict_pkg::CMD_PASS_STEP;
         hict_pkg::S_PASS_END:   cmd.op = hict_pkg::CMD_PASS_END;
         hict_pkg::S_CLR_INIT:   cmd.op = hict_pkg::CMD_SCAN_INIT;
         hict_pkg::S_CLR: begin
            if (!stat.clr_done) begin
               cmd.op = hict_pkg::CMD_CLR;
            end
         end
         hict_pkg::S_CMP_INIT: cmd.op = hict_pkg::CMD_SCAN_INIT;
         hict_pkg::S_CMP_RD: begin
            if (!stat.scan_done) begin
               cmd.op = hict_pkg::CMD_RD;
            end
         end
         hict_pkg::S_CMP_STEP: cmd.op = hict_pkg::CMD_CMP_STEP;
         hict_pkg::S_CMP_END:  cmd.op = hict_pkg::CMD_CMP_END;
         hict_pkg::S_DONE: begin
            if (stat.rsp_free) begin
               cmd.op = hict_pkg::CMD_RESP;
            end
         end
         default:              cmd.op = hict_pkg::CMD_NONE;
      endcase
   end

endmodule

[design/hict_dpath.sv]
// Datapath of the hash/id cache table: entry memory, scan counters, sort carry
// register and result register. Depends on hict_pkg; commanded by hict_ctrl.
module hict_dpath #(
   parameter int CAPACITY  = hict_pkg::CAPACITY_DEF,
   parameter int HASH_BITS = hict_pkg::HASH_BITS_DEF,
   parameter int ID_BITS   = hict_pkg::ID_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hict_pkg::cmd_type            cmd,
   input  logic [hict_pkg::IN_BYTES_BITS-1:0] req_data,
   input  logic [8:0]                   table_limit,
   input  logic                         rsp_tready,
   output logic                         rsp_tvalid,
   output logic [hict_pkg::OUT_BITS-1:0] rsp_tdata,
   output hict_pkg::stat_type           stat
);

   localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int NW  = $clog2(CAPACITY + 1);
   localparam int CW  = (NW > 9) ? NW : 9;
   localparam int HB  = hict_pkg::HITS_BITS;

   logic [HASH_BITS-1:0] mem_hash [CAPACITY];
   logic [ID_BITS-1:0]   mem_id   [CAPACITY];
   logic [HB-1:0]        mem_hits [CAPACITY];

   logic [HASH_BITS-1:0] rd_hash_ff, carry_hash_ff, carry_hash_in, key_ff;
   logic [ID_BITS-1:0]   rd_id_ff, carry_id_ff, carry_id_in, id_ff;
   logic [HB-1:0]        rd_hits_ff, carry_hits_ff, carry_hits_in;
   logic [7:0]           slot_ff, found_ff, found_in;
   logic [1:0]           status_ff, status_in;
   logic [NW-1:0]        used_ff, used_in, idx_ff, idx_in, wp_ff, wp_in;
   logic                 swapped_ff, swapped_in, by_hits_ff, by_hits_in;
   logic                 rsp_valid_ff;
   logic [hict_pkg::OUT_BITS-1:0] rsp_data_ff;

   logic                 we;
   logic [AW-1:0]        wa;
   logic [HASH_BITS-1:0] wd_hash;
   logic [ID_BITS-1:0]   wd_id;
   logic [HB-1:0]        wd_hits;
   logic [CW-1:0]        used_w, eff_w, limit_w, slot_w;
   logic [HB:0]          carry_key, rd_key;
   logic                 greater;
   logic [NW-1:0]        idx_prev, used_prev;

   assign used_w    = CW'(used_ff);
   assign limit_w   = CW'(table_limit);
   assign slot_w    = CW'(slot_ff);
   assign eff_w     = (limit_w < CW'(CAPACITY)) ? limit_w : CW'(CAPACITY);
   assign carry_key = (carry_id_ff != '0) ? ({1'b0, carry_hits_ff} + 1'b1) : '0;
   assign rd_key    = (rd_id_ff != '0) ? ({1'b0, rd_hits_ff} + 1'b1) : '0;
   assign greater   = by_hits_ff ? (carry_key > rd_key) : (carry_hash_ff > rd_hash_ff);
   assign idx_prev  = idx_ff - 1'b1;
   assign used_prev = used_ff - 1'b1;

   assign stat.scan_done = idx_ff >= used_ff;
   assign stat.match     = rd_hash_ff == key_ff;
   assign stat.last      = idx_ff == used_prev;
   assign stat.swapped   = swapped_ff;
   assign stat.by_hits   = by_hits_ff;
   assign stat.clr_done  = idx_ff >= (used_ff >> 1);
   assign stat.few       = used_ff < NW'(2);
   assign stat.evict_ok  = (used_ff >= NW'(2)) && (used_w >= (eff_w >> 1));
   assign stat.rsp_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      we            = 1'b0;
      wa            = idx_ff[AW-1:0];
      wd_hash       = '0;
      wd_id         = '0;
      wd_hits       = '0;
      used_in       = used_ff;
      idx_in        = idx_ff;
      wp_in         = wp_ff;
      swapped_in    = swapped_ff;
      by_hits_in    = by_hits_ff;
      carry_hash_in = carry_hash_ff;
      carry_id_in   = carry_id_ff;
      carry_hits_in = carry_hits_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      case (cmd.op)
         hict_pkg::CMD_LOAD: begin
            status_in = hict_pkg::ST_OK;
            found_in  = '0;
            idx_in    = '0;
         end
         hict_pkg::CMD_ADD: begin
            if (used_w >= eff_w) begin
               status_in = hict_pkg::ST_FULL;
            end else begin
               we      = 1'b1;
               wa      = used_ff[AW-1:0];
               wd_hash = key_ff;
               wd_id   = id_ff;
               used_in = used_ff + 1'b1;
            end
         end
         hict_pkg::CMD_NEXT: idx_in = idx_ff + 1'b1;
         hict_pkg::CMD_LK_HIT: begin
            we       = 1'b1;
            wd_hash  = rd_hash_ff;
            wd_id    = rd_id_ff;
            wd_hits  = (rd_hits_ff != '1) ? rd_hits_ff + 1'b1 : rd_hits_ff;
            found_in = 8'(idx_ff);
         end
         hict_pkg::CMD_LK_MISS: status_in = hict_pkg::ST_NOTFOUND;
         hict_pkg::CMD_WIPE: begin
            if (slot_w >= used_w) begin
               status_in = hict_pkg::ST_RANGE;
            end else begin
               we = 1'b1;
               wa = AW'(slot_ff);
            end
         end
         hict_pkg::CMD_PASS_INIT: begin
            idx_in     = '0;
            swapped_in = 1'b0;
            by_hits_in = cmd.by_hits;
         end
         hict_pkg::CMD_PASS_FIRST: begin
            carry_hash_in = rd_hash_ff;
            carry_id_in   = rd_id_ff;
            carry_hits_in = rd_hits_ff;
            idx_in        = idx_ff + 1'b1;
         end
         hict_pkg::CMD_PASS_STEP: begin
            we     = 1'b1;
            wa     = idx_prev[AW-1:0];
            idx_in = idx_ff + 1'b1;
            if (greater) begin
               wd_hash    = rd_hash_ff;
               wd_id      = rd_id_ff;
               wd_hits    = rd_hits_ff;
               swapped_in = 1'b1;
            end else begin
               wd_hash       = carry_hash_ff;
               wd_id         = carry_id_ff;
               wd_hits       = carry_hits_ff;
               carry_hash_in = rd_hash_ff;
               carry_id_in   = rd_id_ff;
               carry_hits_in = rd_hits_ff;
            end
         end
         hict_pkg::CMD_PASS_END: begin
            we      = 1'b1;
            wa      = used_prev[AW-1:0];
            wd_hash = carry_hash_ff;
            wd_id   = carry_id_ff;
            wd_hits = carry_hits_ff;
         end
         hict_pkg::CMD_CLR: begin
            we     = 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         hict_pkg::CMD_SCAN_INIT: begin
            idx_in = '0;
            wp_in  = '0;
         end
         hict_pkg::CMD_CMP_STEP: begin
            idx_in = idx_ff + 1'b1;
            if (rd_id_ff != '0) begin
               we      = 1'b1;
               wa      = wp_ff[AW-1:0];
               wd_hash = rd_hash_ff;
               wd_id   = rd_id_ff;
               wd_hits = rd_hits_ff;
               wp_in   = wp_ff + 1'b1;
            end
         end
         hict_pkg::CMD_CMP_END: begin
            if (wp_ff != '0) begin
               used_in = wp_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_hash[wa] <= wd_hash;
         mem_id[wa]   <= wd_id;
         mem_hits[wa] <= wd_hits;
      end
      if (cmd.op == hict_pkg::CMD_RD) begin
         rd_hash_ff <= mem_hash[idx_ff[AW-1:0]];
         rd_id_ff   <= mem_id[idx_ff[AW-1:0]];
         rd_hits_ff <= mem_hits[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == hict_pkg::CMD_LOAD) begin
         key_ff  <= HASH_BITS'(req_data[34:3]);
         id_ff   <= ID_BITS'(req_data[50:35]);
         slot_ff <= req_data[58:51];
      end
      if (cmd.op == hict_pkg::CMD_RESP) begin
         rsp_data_ff <= hict_pkg::OUT_BITS'({used_w[8:0], found_ff, status_ff});
      end
      idx_ff        <= idx_in;
      wp_ff         <= wp_in;
      swapped_ff    <= swapped_in;
      by_hits_ff    <= by_hits_in;
      carry_hash_ff <= carry_hash_in;
      carry_id_ff   <= carry_id_in;
      carry_hits_ff <= carry_hits_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         if (cmd.op == hict_pkg::CMD_RESP) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[design/hash_id_cache_table_top.sv]
// Top level of the hash/id cache table: stream ports, APB register, sequencer
// and datapath. Depends on hict_pkg, hict_ctrl and hict_dpath.
//
//  Channel  Direction  Handshake                 Contents
//  req      in         req_tvalid / req_tready   func, key_hash, entry_id, slot_index
//  rsp      out        rsp_tvalid / rsp_tready   status, found_index, entry_count
//  csr      in/out     APB psel/penable/pready   table_limit at every address
//
// One request at a time. Sort and evict run bubble passes through the single-port
// entry memory, up to one pass per entry, plus a compaction pass; evict adds a
// clearing pass, one cleared entry per cycle, and a second sort. Reset is
// synchronous; the entries are undefined until written. The result waits in an
// output register; the next request holds in its final state until that result
// is taken.
module hash_id_cache_table_top #(
   parameter int CAPACITY  = hict_pkg::CAPACITY_DEF,
   parameter int HASH_BITS = hict_pkg::HASH_BITS_DEF,
   parameter int ID_BITS   = hict_pkg::ID_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] func, [34:3] key_hash, [50:35] entry_id, [58:51] slot_index
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [9:2] found_index, [18:10] entry_count
   output logic [23:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [8:0]         limit_ff;
   logic               idle, take;
   hict_pkg::cmd_type  cmd;
   hict_pkg::stat_type stat;
   logic [hict_pkg::OUT_BITS-1:0] dp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= hict_pkg::LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         limit_ff <= csr_pwdata[8:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? 32'(limit_ff) : 32'(limit_ff);
   assign req_tready = idle;
   assign take       = req_tvalid && idle;
   assign rsp_tdata  = dp_data;

   hict_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_take (take),
      .req_func (req_tdata[2:0]),
      .stat     (stat),
      .idle     (idle),
      .cmd      (cmd)
   );

   hict_dpath #(
      .CAPACITY  (CAPACITY),
      .HASH_BITS (HASH_BITS),
      .ID_BITS   (ID_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_tdata),
      .table_limit (limit_ff),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (dp_data),
      .stat        (stat)
   );

endmodule

[design/hict_checker.sv]
// Port-level checks of the hash/id cache table, bound to the top level.
// Depends on hict_pkg for the status codes and on the top level's ports.
module hict_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while one is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != hict_pkg::ST_OK) |-> (rsp_tdata[9:2] == 8'd0))
      else $error("found index set on failed request");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[18:10] <= 9'd256))
      else $error("entry count out of range");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid || $past(rsp_tvalid))
      else $error("result appeared in the cycle after acceptance");

endmodule

bind hash_id_cache_table_top hict_checker u_hict_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
